>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared types, codes and default sizes for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

   localparam int DEF_FRAC_BITS = 8;
   localparam int DEF_MID_DEPTH = 4;
   localparam int DEF_OUT_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DIV0 = 2'd1,
      ST_OVF  = 2'd2
   } status_type;

   typedef struct packed {
      op_type             op;
      logic signed [15:0] a_re;
      logic signed [15:0] a_im;
      logic signed [15:0] b_re;
      logic signed [15:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [31:0] re_out;
      logic signed [31:0] im_out;
      status_type         status;
   } rsp_type;

   // Operands plus all partial products, as handed from front to back.
   typedef struct packed {
      op_type             op;
      logic signed [15:0] a_re;
      logic signed [15:0] a_im;
      logic signed [15:0] b_re;
      logic signed [15:0] b_im;
      logic signed [31:0] p_ac;
      logic signed [31:0] p_bd;
      logic signed [31:0] p_ad;
      logic signed [31:0] p_bc;
      logic signed [31:0] p_cc;
      logic signed [31:0] p_dd;
   } prod_type;

   localparam logic signed [31:0] SAT_MAX = {1'b0, {31{1'b1}}};
   localparam logic signed [31:0] SAT_MIN = {1'b1, {31{1'b0}}};

   // Clamp a 33-bit signed value into 32 bits.
   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? SAT_MIN : SAT_MAX;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic ovf33(input logic signed [32:0] v);
      return v[32] != v[31];
   endfunction

endpackage

`default_nettype wire

>>> hdl/complex_arithmetic_unit.sv
// Throughput: one beat per cycle unless a full result queue stalls the back end;
// the divider is a pipeline of one quotient bit per stage.
// The back end holds its whole pipeline while the result queue is full.
// Reset is synchronous and active high; it empties both queues and all valid bits.
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Adds, subtracts, multiplies or divides two Q8.8 complex values into Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module complex_arithmetic_unit #(
   parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS,
   parameter int MID_DEPTH = cau_pkg::DEF_MID_DEPTH,
   parameter int OUT_DEPTH = cau_pkg::DEF_OUT_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire cau_pkg::req_type req_data,
   output logic                  full,
   output logic                  empty,
   input  wire logic             pop,
   output cau_pkg::rsp_type      rsp_data
);

   // The front end registers the four cross products and both squares of the
   // divisor. A short queue separates it from the back end so that either can
   // stall while the other keeps working.
   logic              mid_push, mid_full, mid_pop, mid_empty;
   cau_pkg::prod_type mid_wdata, mid_rdata;

   // The back end writes finished beats into the result queue, which the
   // consumer drains with pop.
   logic              out_push, out_full;
   cau_pkg::rsp_type  out_wdata;

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .mid_push (mid_push),
      .mid_data (mid_wdata),
      .mid_full (mid_full)
   );

   cau_fifo #(
      .WIDTH ($bits(cau_pkg::prod_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mid_push),
      .wr_data (mid_wdata),
      .full    (mid_full),
      .rd_en   (mid_pop),
      .rd_data (mid_rdata),
      .empty   (mid_empty)
   );

   // Add, subtract and multiply results are final after the entry stage and
   // simply ride along with the divider stages so that order is kept.
   cau_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_rdata),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wdata)
   );

   cau_fifo #(
      .WIDTH ($bits(cau_pkg::rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_wdata),
      .full    (out_full),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

   // The back end must never write a beat the result queue cannot hold.
   `ASSERT_CLK(a_out_no_overrun, clock, reset, out_push |-> !out_full, "result queue overrun")

   // A divide by zero always carries zero parts.
   `ASSERT_CLK(a_div0_zero, clock, reset,
      (!empty && rsp_data.status == cau_pkg::ST_DIV0) |->
      (rsp_data.re_out == '0 && rsp_data.im_out == '0), "divide by zero with nonzero parts")

   // Reset leaves no result pending.
   `ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> empty, "result pending after reset")

endmodule

`default_nettype wire

>>> hdl/cau_fifo.sv
// ----------------------------------------------------------------------------
// Small queue
// First-in first-out store with count-based full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wptr_ff, rptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem[rptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_wr) begin
            wptr_ff <= (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + AW'(1);
         end
         if (do_rd) begin
            rptr_ff <= (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + AW'(1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/cau_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts operand beats and forms all partial products in one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cau_pkg::req_type  req_data,
   output logic                   full,
   output logic                   mid_push,
   output cau_pkg::prod_type      mid_data,
   input  wire logic              mid_full
);

   logic              valid_ff;
   cau_pkg::prod_type prod_ff, prod_in;
   logic              take;

   assign full     = valid_ff && mid_full;
   assign take     = push && !full;
   assign mid_push = valid_ff;
   assign mid_data = prod_ff;

   always_comb begin
      prod_in.op   = req_data.op;
      prod_in.a_re = req_data.a_re;
      prod_in.a_im = req_data.a_im;
      prod_in.b_re = req_data.b_re;
      prod_in.b_im = req_data.b_im;
      prod_in.p_ac = req_data.a_re * req_data.b_re;
      prod_in.p_bd = req_data.a_im * req_data.b_im;
      prod_in.p_ad = req_data.a_re * req_data.b_im;
      prod_in.p_bc = req_data.a_im * req_data.b_re;
      prod_in.p_cc = req_data.b_re * req_data.b_re;
      prod_in.p_dd = req_data.b_im * req_data.b_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (!mid_full) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/cau_back.sv
// ----------------------------------------------------------------------------
// Back end
// Finishes add, subtract and multiply and runs the pipelined divider.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_back #(
   parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              mid_empty,
   input  wire cau_pkg::prod_type mid_data,
   output logic                   mid_pop,
   input  wire logic              out_full,
   output logic                   out_push,
   output cau_pkg::rsp_type       out_data
);

   localparam int NW = 32 + 2 * FRAC_BITS;
   localparam int WW = NW + 1;

   logic adv;
   assign adv     = !out_full;
   assign mid_pop = adv && !mid_empty;

   logic             v_ff   [NW+1];
   logic             div_ff [NW+1];
   logic             nr_ff  [NW+1];
   logic             ni_ff  [NW+1];
   cau_pkg::rsp_type res_ff [NW+1];
   logic [NW-1:0]    dqr_ff [NW+1];
   logic [NW-1:0]    dqi_ff [NW+1];
   logic [31:0]      rr_ff  [NW+1];
   logic [31:0]      ri_ff  [NW+1];
   logic [31:0]      den_ff [NW+1];

   // Entry stage: sums, saturation of the direct results, divider set-up.
   logic signed [16:0] s_re, s_im;
   logic signed [32:0] x_re, x_im, n_re, n_im;
   logic [31:0]        den_in, m_re, m_im;
   cau_pkg::rsp_type   res_in;
   logic               div_in;

   always_comb begin
      s_re   = 17'(mid_data.a_re) + 17'(mid_data.b_re);
      s_im   = 17'(mid_data.a_im) + 17'(mid_data.b_im);
      x_re   = '0;
      x_im   = '0;
      div_in = 1'b0;
      n_re   = 33'(mid_data.p_ac) + 33'(mid_data.p_bd);
      n_im   = 33'(mid_data.p_bc) - 33'(mid_data.p_ad);
      den_in = 32'(mid_data.p_cc) + 32'(mid_data.p_dd);
      unique case (mid_data.op)
         cau_pkg::OP_ADD: begin
            x_re = 33'(s_re) <<< FRAC_BITS;
            x_im = 33'(s_im) <<< FRAC_BITS;
         end
         cau_pkg::OP_SUB: begin
            x_re = (33'(mid_data.a_re) - 33'(mid_data.b_re)) <<< FRAC_BITS;
            x_im = (33'(mid_data.a_im) - 33'(mid_data.b_im)) <<< FRAC_BITS;
         end
         cau_pkg::OP_MUL: begin
            x_re = 33'(mid_data.p_ac) - 33'(mid_data.p_bd);
            x_im = 33'(mid_data.p_ad) + 33'(mid_data.p_bc);
         end
         cau_pkg::OP_DIV: begin
            div_in = (den_in != '0);
         end
      endcase
      m_re = n_re[32] ? 32'(-n_re) : n_re[31:0];
      m_im = n_im[32] ? 32'(-n_im) : n_im[31:0];
      res_in.re_out = cau_pkg::sat33(x_re);
      res_in.im_out = cau_pkg::sat33(x_im);
      if (mid_data.op == cau_pkg::OP_DIV) begin
         res_in.status = cau_pkg::ST_DIV0;
      end else if (cau_pkg::ovf33(x_re) || cau_pkg::ovf33(x_im)) begin
         res_in.status = cau_pkg::ST_OVF;
      end else begin
         res_in.status = cau_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= !mid_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= div_in;
         nr_ff[0]  <= n_re[32];
         ni_ff[0]  <= n_im[32];
         res_ff[0] <= res_in;
         dqr_ff[0] <= NW'(m_re) << (2 * FRAC_BITS);
         dqi_ff[0] <= NW'(m_im) << (2 * FRAC_BITS);
         rr_ff[0]  <= '0;
         ri_ff[0]  <= '0;
         den_ff[0] <= den_in;
      end
   end

   // One restoring quotient bit per stage for each part.
   for (genvar k = 1; k <= NW; k++) begin : g_stage
      logic [32:0] r2r, r2i;
      logic        ger, gei;
      logic [31:0] rr_in, ri_in;

      always_comb begin
         r2r   = {rr_ff[k-1], dqr_ff[k-1][NW-1]};
         r2i   = {ri_ff[k-1], dqi_ff[k-1][NW-1]};
         ger   = (r2r >= {1'b0, den_ff[k-1]});
         gei   = (r2i >= {1'b0, den_ff[k-1]});
         rr_in = ger ? 32'(r2r - {1'b0, den_ff[k-1]}) : r2r[31:0];
         ri_in = gei ? 32'(r2i - {1'b0, den_ff[k-1]}) : r2i[31:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k] <= div_ff[k-1];
            nr_ff[k]  <= nr_ff[k-1];
            ni_ff[k]  <= ni_ff[k-1];
            res_ff[k] <= res_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            rr_ff[k]  <= rr_in;
            ri_ff[k]  <= ri_in;
            dqr_ff[k] <= {dqr_ff[k-1][NW-2:0], ger};
            dqi_ff[k] <= {dqi_ff[k-1][NW-2:0], gei};
         end
      end
   end

   // Sign, saturation and status of the finished quotient.
   logic signed [WW-1:0] q_re, q_im;
   logic                 o_re, o_im;

   always_comb begin
      q_re = nr_ff[NW] ? -$signed({1'b0, dqr_ff[NW]}) : $signed({1'b0, dqr_ff[NW]});
      q_im = ni_ff[NW] ? -$signed({1'b0, dqi_ff[NW]}) : $signed({1'b0, dqi_ff[NW]});
      o_re = !((&q_re[WW-1:31]) || !(|q_re[WW-1:31]));
      o_im = !((&q_im[WW-1:31]) || !(|q_im[WW-1:31]));
      out_push = adv && v_ff[NW];
      if (div_ff[NW]) begin
         out_data.re_out = o_re ? (q_re[WW-1] ? cau_pkg::SAT_MIN : cau_pkg::SAT_MAX)
                                : q_re[31:0];
         out_data.im_out = o_im ? (q_im[WW-1] ? cau_pkg::SAT_MIN : cau_pkg::SAT_MAX)
                                : q_im[31:0];
         out_data.status = (o_re || o_im) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
      end else begin
         out_data = res_ff[NW];
      end
   end

endmodule

`default_nettype wire

>>> sim/complex_arithmetic_unit_test.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Sends complex operand pairs with all four operations and checks every
// result against a predictor built into this bench.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit_test;

   localparam int LATENCY     = 2 * cau_pkg::DEF_FRAC_BITS + 35;
   localparam int CYCLE_LIMIT = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             push  = 1'b0;
   logic             pop   = 1'b0;
   cau_pkg::req_type req_data = '0;
   logic             full;
   logic             empty;
   cau_pkg::rsp_type rsp_data;

   // Expected results, oldest first.
   cau_pkg::rsp_type expected_results[$];
   int      error_count = 0;
   int      cycle_count = 0;
   // When set, the receiver stops popping for a long stretch.
   bit      hold_off_request = 1'b0;
   bit      hold_off_done    = 1'b0;

   complex_arithmetic_unit dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #2 clock = ~clock;

   // Clamp a wide value to 32 signed bits and note whether it was clamped.
   function automatic logic signed [31:0] clamp32(input longint v, inout bit clamped);
      if (v > 64'sd2147483647) begin
         clamped = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         clamped = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Work out the complex result that one operand pair should produce.
   function automatic cau_pkg::rsp_type complex_result(input cau_pkg::req_type r);
      longint  a, b, c, d, den, re, im;
      bit      clamped;
      cau_pkg::rsp_type res;
      a = r.a_re;
      b = r.a_im;
      c = r.b_re;
      d = r.b_im;
      re = 0;
      im = 0;
      clamped = 1'b0;
      res.status = cau_pkg::ST_OK;
      case (r.op)
         cau_pkg::OP_ADD: begin
            re = (a + c) <<< cau_pkg::DEF_FRAC_BITS;
            im = (b + d) <<< cau_pkg::DEF_FRAC_BITS;
         end
         cau_pkg::OP_SUB: begin
            re = (a - c) <<< cau_pkg::DEF_FRAC_BITS;
            im = (b - d) <<< cau_pkg::DEF_FRAC_BITS;
         end
         cau_pkg::OP_MUL: begin
            re = a * c - b * d;
            im = a * d + b * c;
         end
         default: begin
            den = c * c + d * d;
            if (den == 0) begin
               res.status = cau_pkg::ST_DIV0;
            end else begin
               // SystemVerilog division truncates toward zero, as required.
               re = ((a * c + b * d) <<< (2 * cau_pkg::DEF_FRAC_BITS)) / den;
               im = ((b * c - a * d) <<< (2 * cau_pkg::DEF_FRAC_BITS)) / den;
            end
         end
      endcase
      res.re_out = clamp32(re, clamped);
      res.im_out = clamp32(im, clamped);
      if (clamped) res.status = cau_pkg::ST_OVF;
      return res;
   endfunction

   // Cycle counter and the overall time limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  expected_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: stalls on its own pattern, plus one long hold-off on request.
   // Pop is decided at each edge; a result is taken at an edge where the
   // previous pop was high and empty low.
   int stall_phase = 0;
   int hold_count  = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, actual %h", $time, rsp_data);
               error_count++;
            end else begin
               cau_pkg::rsp_type want;
               want = expected_results.pop_front();
               if (rsp_data.re_out !== want.re_out)
                  $display("%0t: re_out expected %h actual %h", $time,
                           want.re_out, rsp_data.re_out);
               if (rsp_data.im_out !== want.im_out)
                  $display("%0t: im_out expected %h actual %h", $time,
                           want.im_out, rsp_data.im_out);
               if (rsp_data.status !== want.status)
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_data.status);
               if (rsp_data !== want) error_count++;
            end
         end
         if (hold_off_request && !hold_off_done) begin
            pop <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count >= 300) hold_off_done <= 1'b1;
         end else begin
            // Stretches of steady popping alternate with random stalls.
            stall_phase <= (stall_phase + 1) % 64;
            pop <= (stall_phase < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Offer one beat and hold it until it is accepted; push stays high on
   // return so that back-to-back beats do not drop it.
   task automatic send_beat(input cau_pkg::req_type r);
      push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      expected_results.push_back(complex_result(r));
   endtask

   task automatic idle_cycles(input int n);
      push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'($urandom_range(0, 1023) - 512);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic cau_pkg::req_type rand_beat();
      cau_pkg::req_type r;
      r.op   = cau_pkg::op_type'($urandom_range(0, 3));
      r.a_re = rand_operand();
      r.a_im = rand_operand();
      r.b_re = rand_operand();
      r.b_im = rand_operand();
      // Divides by zero show up now and then.
      if (r.op == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0) begin
         r.b_re = '0;
         r.b_im = '0;
      end
      return r;
   endfunction

   // Extreme operands, every operation, zero divisor and saturation.
   task automatic test_directed();
      cau_pkg::req_type r;
      logic signed [15:0] ext[4];
      ext = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0100};
      for (int o = 0; o < 4; o++) begin
         for (int k = 0; k < 4; k++) begin
            r.op   = cau_pkg::op_type'(o);
            r.a_re = ext[k];
            r.a_im = ext[(k + 1) % 4];
            r.b_re = ext[(k + 2) % 4];
            r.b_im = ext[(k + 3) % 4];
            send_beat(r);
         end
      end
      // Zero divisor.
      send_beat('{cau_pkg::OP_DIV, 16'sh1234, -16'sh0567, 16'sh0000, 16'sh0000});
      // Multiply whose imaginary part reaches 2^31 and saturates.
      send_beat('{cau_pkg::OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
      // Divide by the smallest divisor; the quotient reaches the bottom of the range without saturating.
      send_beat('{cau_pkg::OP_DIV, 16'sh7FFF, 16'sh8000, 16'sh0001, 16'sh0000});
      // Negative quotient that must truncate toward zero.
      send_beat('{cau_pkg::OP_DIV, -16'sh0001, 16'sh0000, 16'sh0003, 16'sh0000});
      drain();
   endtask

   // Bursts of random beats with random gaps between them.
   task automatic test_random_bursts(input int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         int burst;
         burst = $urandom_range(1, 30);
         for (int i = 0; i < burst && sent < n; i++) begin
            send_beat(rand_beat());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
      end
   endtask

   // The receiver holds off while the sender keeps pushing, so the unit
   // fills up and raises full.
   task automatic test_back_pressure();
      hold_off_request = 1'b1;
      for (int i = 0; i < 150; i++) send_beat(rand_beat());
      push <= 1'b0;
      while (!hold_off_done) @(posedge clock);
      hold_off_request = 1'b0;
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_bursts(350);
      // The sender pauses until every result is back.
      drain();
      test_back_pressure();
      test_random_bursts(350);
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
+incdir+hdl
hdl/cau_pkg.sv
hdl/cau_fifo.sv
hdl/cau_front.sv
hdl/cau_back.sv
hdl/complex_arithmetic_unit.sv
sim/complex_arithmetic_unit_test.sv
